### rtl/core/tlprq_pkg.sv
package tlprq_pkg;

    localparam int ID_W       = 8;
    localparam int KIND_W     = 2;
    localparam int PRIO_W     = 2;
    localparam int TOTAL_W    = 7;
    localparam int NUM_LEVELS = 3;

    // Request kinds.
    localparam logic [KIND_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] REQ_POP    = 2'd1;
    localparam logic [KIND_W-1:0] REQ_REMOVE = 2'd2;

    // Level codes.
    localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd1;
    localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd2;
    localparam logic [PRIO_W-1:0] PRIO_NONE   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_POP_DATA,
        ST_SEARCH,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic push_write;
        logic pop_read;
        logic pop_take;
        logic srch_init;
        logic srch_step;
        logic shift_init;
        logic shift_step;
        logic rem_done;
    } t_cmd;

    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic is_remove;
        logic req_ok;
        logic lvl_not_full;
        logic any_nonempty;
        logic more;
        logic match;
        logic pend;
    } t_status;

endpackage

### rtl/core/tlprq_ram.sv
module tlprq_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 96
    )
    (
        input  logic                     i_clk,
        input  logic                     i_we,
        input  logic [$clog2(DEPTH)-1:0] i_waddr,
        input  logic [WIDTH-1:0]         i_wdata,
        input  logic [$clog2(DEPTH)-1:0] i_raddr,
        output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tlprq_dp.sv
module tlprq_dp
    import tlprq_pkg::*;
    #(
        parameter int QUEUE_DEPTH = 32,
        parameter int MAX_THREADS = 256
    )
    (
        input  logic               i_clk,
        input  logic               i_rst_n,
        input  t_cmd               i_cmd,
        input  logic [KIND_W-1:0]  i_req_type,
        input  logic [ID_W-1:0]    i_thread_id,
        input  logic [PRIO_W-1:0]  i_priority_req,
        output t_status            o_status,
        output logic [ID_W-1:0]    o_out_thread,
        output logic               o_ok,
        output logic [TOTAL_W-1:0] o_total_count
    );

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int MEM_D = NUM_LEVELS * QUEUE_DEPTH;
    localparam int AW    = $clog2(MEM_D);
    localparam int TOT_W = CNT_W + 2;

    logic [KIND_W-1:0] r_kind;
    logic [ID_W-1:0]   r_tid;
    logic [PRIO_W-1:0] r_lvl;
    logic [ID_W-1:0]   r_out;
    logic              r_ok;
    logic [CNT_W-1:0]  r_cnt  [NUM_LEVELS];
    logic [PTR_W-1:0]  r_head [NUM_LEVELS];
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cidx;
    logic              r_cval;
    logic              r_pend;
    logic [PTR_W-1:0]  r_widx;

    logic [PRIO_W-1:0] w_sel_lvl;
    logic [CNT_W-1:0]  w_cnt_sel;
    logic [PTR_W-1:0]  w_head_sel;
    logic [AW-1:0]     w_base;
    logic [PRIO_W-1:0] w_pop_lvl;
    logic [PTR_W-1:0]  w_rd_rel;
    logic [PTR_W-1:0]  w_wr_rel;
    logic [AW-1:0]     w_raddr;
    logic [AW-1:0]     w_waddr;
    logic              w_we;
    logic [ID_W-1:0]   w_wdata;
    logic [ID_W-1:0]   w_rd_data;
    logic [TOT_W-1:0]  w_total;

    // Slot of a position counted from a level's head, wrapped once.
    function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] base,
                                                input logic [PTR_W-1:0] head,
                                                input logic [PTR_W-1:0] rel);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, rel};
        if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return base + AW'(sum);
    endfunction

    // A pop reads the head of the highest non-empty level, not the level of the request.
    assign w_sel_lvl = i_cmd.pop_read ? w_pop_lvl : r_lvl;

    always_comb begin
        unique case (w_sel_lvl)
            PRIO_LOW: begin
                w_cnt_sel  = r_cnt[0];
                w_head_sel = r_head[0];
                w_base     = '0;
            end
            PRIO_NORMAL: begin
                w_cnt_sel  = r_cnt[1];
                w_head_sel = r_head[1];
                w_base     = AW'(QUEUE_DEPTH);
            end
            PRIO_HIGH: begin
                w_cnt_sel  = r_cnt[2];
                w_head_sel = r_head[2];
                w_base     = AW'(2 * QUEUE_DEPTH);
            end
            default: begin
                w_cnt_sel  = '0;
                w_head_sel = '0;
                w_base     = '0;
            end
        endcase
    end

    always_comb begin
        priority if (r_cnt[2] != '0) begin
            w_pop_lvl = PRIO_HIGH;
        end else if (r_cnt[1] != '0) begin
            w_pop_lvl = PRIO_NORMAL;
        end else begin
            w_pop_lvl = PRIO_LOW;
        end
    end

    assign w_rd_rel = i_cmd.pop_read ? '0 : r_idx[PTR_W-1:0];
    assign w_wr_rel = i_cmd.push_write ? w_cnt_sel[PTR_W-1:0] : r_widx;
    assign w_raddr  = slot_addr(w_base, w_head_sel, w_rd_rel);
    assign w_waddr  = slot_addr(w_base, w_head_sel, w_wr_rel);
    assign w_we     = i_cmd.push_write | (i_cmd.shift_step & r_pend);
    assign w_wdata  = i_cmd.push_write ? r_tid : w_rd_data;

    tlprq_ram #(
        .WIDTH (ID_W),
        .DEPTH (MEM_D)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    // Request, result and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_req_type;
            r_tid  <= i_thread_id;
            r_lvl  <= i_priority_req;
            r_out  <= '0;
            r_ok   <= 1'b0;
        end
        if (i_cmd.push_write || i_cmd.rem_done) begin
            r_ok <= 1'b1;
        end
        if (i_cmd.pop_read) begin
            r_lvl <= w_pop_lvl;
        end
        if (i_cmd.pop_take) begin
            r_out <= w_rd_data;
            r_ok  <= 1'b1;
        end
        if (i_cmd.srch_init) begin
            r_idx  <= '0;
            r_cval <= 1'b0;
            r_pend <= 1'b0;
        end
        if (i_cmd.srch_step) begin
            r_cidx <= r_idx;
            r_cval <= o_status.more;
            if (o_status.more) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
        if (i_cmd.shift_init) begin
            r_idx  <= r_cidx + CNT_W'(1);
            r_pend <= 1'b0;
        end
        if (i_cmd.shift_step) begin
            r_pend <= o_status.more;
            if (o_status.more) begin
                r_widx <= PTR_W'(r_idx - CNT_W'(1));
                r_idx  <= r_idx + CNT_W'(1);
            end
        end
    end

    // Level counts and head pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_cnt[l]  <= '0;
                r_head[l] <= '0;
            end
        end else begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (r_lvl == PRIO_W'(l)) begin
                    if (i_cmd.push_write) begin
                        r_cnt[l] <= r_cnt[l] + CNT_W'(1);
                    end
                    if (i_cmd.pop_take || i_cmd.rem_done) begin
                        r_cnt[l] <= r_cnt[l] - CNT_W'(1);
                    end
                    if (i_cmd.pop_take) begin
                        if (r_head[l] == PTR_W'(QUEUE_DEPTH - 1)) begin
                            r_head[l] <= '0;
                        end else begin
                            r_head[l] <= r_head[l] + PTR_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        o_status.is_push      = (r_kind == REQ_PUSH);
        o_status.is_pop       = (r_kind == REQ_POP);
        o_status.is_remove    = (r_kind == REQ_REMOVE);
        o_status.req_ok       = (r_lvl != PRIO_NONE) && ({24'd0, r_tid} < MAX_THREADS);
        o_status.lvl_not_full = (w_cnt_sel < CNT_W'(QUEUE_DEPTH));
        o_status.any_nonempty = (r_cnt[0] != '0) || (r_cnt[1] != '0) || (r_cnt[2] != '0);
        o_status.more         = (r_idx < w_cnt_sel);
        o_status.match        = r_cval && (w_rd_data == r_tid);
        o_status.pend         = r_pend;
    end

    assign w_total       = TOT_W'(r_cnt[0]) + TOT_W'(r_cnt[1]) + TOT_W'(r_cnt[2]);
    assign o_out_thread  = r_out;
    assign o_ok          = r_ok;
    assign o_total_count = TOTAL_W'(w_total);

endmodule

### rtl/core/tlprq_ctrl.sv
module tlprq_ctrl
    import tlprq_pkg::*;
    (
        input  logic    i_clk,
        input  logic    i_rst_n,
        input  logic    i_in_valid,
        input  logic    i_out_stall,
        input  t_status i_status,
        output t_cmd    o_cmd,
        output logic    o_in_stall,
        output logic    o_out_valid
    );

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                priority if (i_status.is_pop && i_status.any_nonempty) begin
                    n_state = ST_POP_DATA;
                end else if (i_status.is_remove && i_status.req_ok) begin
                    n_state = ST_SEARCH;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_POP_DATA: begin
                n_state = ST_DONE;
            end
            ST_SEARCH: begin
                priority if (i_status.match) begin
                    n_state = ST_SHIFT;
                end else if (!i_status.more && !i_status.pend) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SHIFT: begin
                if (!i_status.more && !i_status.pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_out_stall) begin
                    n_state = w_accept ? ST_DECIDE : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_DECIDE: begin
                o_cmd.push_write = i_status.is_push && i_status.req_ok &&
                                   i_status.lvl_not_full;
                o_cmd.pop_read   = i_status.is_pop && i_status.any_nonempty;
                o_cmd.srch_init  = i_status.is_remove && i_status.req_ok;
            end
            ST_POP_DATA: begin
                o_cmd.pop_take = 1'b1;
            end
            ST_SEARCH: begin
                if (i_status.match) begin
                    o_cmd.shift_init = 1'b1;
                end else begin
                    // Keep stepping while a read is in flight or more entries remain.
                    o_cmd.srch_step = i_status.more || i_status.pend;
                end
            end
            ST_SHIFT: begin
                if (i_status.more || i_status.pend) begin
                    o_cmd.shift_step = 1'b1;
                end else begin
                    o_cmd.rem_done = 1'b1;
                end
            end
            ST_DONE: begin
                o_out_valid   = 1'b1;
                o_in_stall    = i_out_stall;
                o_cmd.capture = i_in_valid && !i_out_stall;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### rtl/core/three_level_priority_ready_queue.sv
// A push or an ignored request goes ST_DECIDE -> ST_DONE; a pop goes ST_DECIDE -> ST_POP_DATA -> ST_DONE.
// A remove reads its level one entry per cycle up to the match and then closes the gap one entry
// per cycle; the single read port of the id RAM sets this pace.
// Throughput: one item at a time; the next item is accepted in the cycle its predecessor's result
// is taken.
// Reset (synchronous, active low) empties all three levels; the id RAM itself is not cleared.
module three_level_priority_ready_queue
    import tlprq_pkg::*;
    #(
        parameter int QUEUE_DEPTH = 32,
        parameter int MAX_THREADS = 256
    )
    (
        input  logic               i_clk,
        input  logic               i_rst_n,
        input  logic               i_in_valid,
        output logic               o_in_stall,
        input  logic [KIND_W-1:0]  i_req_type,
        input  logic [ID_W-1:0]    i_thread_id,
        input  logic [PRIO_W-1:0]  i_priority_req,
        output logic               o_out_valid,
        input  logic               i_out_stall,
        output logic [ID_W-1:0]    o_out_thread,
        output logic               o_ok,
        output logic [TOTAL_W-1:0] o_total_count
    );

    // The controller sequences each request; the datapath holds the levels, the id RAM and
    // the result registers. Every level is a circular buffer: a pop only advances the head,
    // while a remove first searches from the head and then moves every later entry one
    // place towards the head, reading one slot ahead of the slot it writes.
    t_cmd    w_cmd;
    t_status w_status;

    tlprq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The result registers and the level counts stay still while the result waits, so the
    // total count shown is the one after this item.
    tlprq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_THREADS (MAX_THREADS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req_type     (i_req_type),
        .i_thread_id    (i_thread_id),
        .i_priority_req (i_priority_req),
        .o_status       (w_status),
        .o_out_thread   (o_out_thread),
        .o_ok           (o_ok),
        .o_total_count  (o_total_count)
    );

endmodule
